// ----- rtl/core/nrmse_pkg.sv -----
// nrmse_pkg: types and constants of the norm ratio block
// no dependencies; used by nrmse_rsp_if, the root unit, the top level and the checker
`timescale 1ns / 1ps

package nrmse_pkg;

   localparam int SUM_W       = 64;
   localparam int RATIO_W     = 32;
   localparam int DIV_STEPS   = 112;
   localparam int SQRT_STEPS  = 32;
   localparam int CNT_W       = $clog2(DIV_STEPS);
   localparam int GUARD_SHIFT = 16;

   localparam logic [SUM_W-1:0]   REF_LIMIT = 64'h0001_0000_0000_0000;
   localparam logic [SUM_W-1:0]   SQRT_BIT0 = 64'h4000_0000_0000_0000;
   localparam logic [RATIO_W-1:0] RATIO_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_ERR,
      ST_SQ_REF,
      ST_ADD_REF,
      ST_CHECK,
      ST_RUN,
      ST_OUT
   } top_state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DIV,
      PH_SQRT
   } phase_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [SUM_W-1:0] divisor;
   } cmd_type;

   typedef struct packed {
      logic               done;
      logic [RATIO_W-1:0] root;
   } sts_type;

endpackage

// ----- rtl/core/nrmse_req_if.sv -----
// nrmse_req_if: input channel carrying one predicted/reference sample pair
// no dependencies
`timescale 1ns / 1ps

interface nrmse_req_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] predicted;
   logic signed [SAMPLE_BITS-1:0] reference;
   logic                          last_sample;

   modport source (output valid, output predicted, output reference, output last_sample,
                   input ready);
   modport sink (input valid, input predicted, input reference, input last_sample,
                 output ready);
endinterface

// ----- rtl/core/nrmse_rsp_if.sv -----
// nrmse_rsp_if: result channel carrying the norm ratio and its flags
// depends on nrmse_pkg
`timescale 1ns / 1ps

interface nrmse_rsp_if ();
   logic                             valid;
   logic                             ready;
   logic [nrmse_pkg::RATIO_W-1:0]    ratio_value;
   logic                             reference_zero;
   logic                             saturated;

   modport source (output valid, output ratio_value, output reference_zero, output saturated,
                   input ready);
   modport sink (input valid, input ratio_value, input reference_zero, input saturated,
                 output ready);
endinterface

// ----- rtl/core/nrmse_norm_ratio_top.sv -----
// nrmse_norm_ratio_top: error norm over reference norm of a stream of sample pairs
// depends on nrmse_pkg, nrmse_req_if, nrmse_rsp_if and nrmse_root_unit
`timescale 1ns / 1ps

// Accumulates saturating sums of (predicted - reference)^2 and reference^2 over
// signed Q3.12 sample pairs and, on a pair marked last, returns
// floor(sqrt(err_sum * 2^48 / ref_sum)) as unsigned Q8.24, then clears the sums.
// A zero reference sum gives 0xFFFFFFFF with reference_zero and saturated set; a
// ratio of 256 or more gives 0xFFFFFFFF with saturated set; a clipped sum sets saturated.
// One transaction at a time: a pair passes through capture, the two uses of one
// shared multiplier and the two sum updates. A last pair adds a check state and,
// unless the result saturates outright, a run in the root unit (one quotient bit,
// then one root bit per cycle on its shared subtractor), then a load of the result
// register. Further pairs are taken while a result waits in that register; the
// next result waits until it is taken.

module nrmse_norm_ratio_top #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   nrmse_req_if.sink    req_if,
   nrmse_rsp_if.source  rsp_if
);
   import nrmse_pkg::*;

   localparam int PROD_W = 2 * SAMPLE_BITS;

   top_state_type          state_ff, state_in;
   logic [SAMPLE_BITS-1:0] dabs_ff, dabs_in;
   logic [SAMPLE_BITS-1:0] rabs_ff, rabs_in;
   logic                   last_ff, last_in;
   logic [SUM_W-1:0]       prod_ff, prod_in;
   logic [SUM_W-1:0]       err_sum_ff, err_sum_in;
   logic [SUM_W-1:0]       ref_sum_ff, ref_sum_in;
   logic                   clip_ff, clip_in;
   logic [RATIO_W-1:0]     ratio_ff, ratio_in;
   logic                   zero_ff, zero_in;
   logic                   sat_ff, sat_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RATIO_W-1:0]     rsp_ratio_ff, rsp_ratio_in;
   logic                   rsp_zero_ff, rsp_zero_in;
   logic                   rsp_sat_ff, rsp_sat_in;

   logic                   req_take;
   logic                   rsp_take;
   logic [SAMPLE_BITS:0]   diff_ext;
   logic [SAMPLE_BITS:0]   ref_ext;
   logic [SAMPLE_BITS:0]   diff_mag;
   logic [SAMPLE_BITS:0]   ref_mag;
   logic [SAMPLE_BITS-1:0] mul_op;
   logic [PROD_W-1:0]      mul_out;
   logic [SUM_W-1:0]       add_base;
   logic [SUM_W:0]         add_out;
   logic [SUM_W-1:0]       add_sat;
   logic                   ref_small;
   logic                   too_big;
   cmd_type                unit_cmd;
   sts_type                unit_sts;

   assign req_take = req_if.valid && req_if.ready;
   assign rsp_take = rsp_if.valid && rsp_if.ready;

   // absolute difference and absolute reference
   assign diff_ext = {req_if.predicted[SAMPLE_BITS-1], req_if.predicted}
                   - {req_if.reference[SAMPLE_BITS-1], req_if.reference};
   assign ref_ext  = {req_if.reference[SAMPLE_BITS-1], req_if.reference};
   assign diff_mag = diff_ext[SAMPLE_BITS] ? (~diff_ext + 1'b1) : diff_ext;
   assign ref_mag  = ref_ext[SAMPLE_BITS] ? (~ref_ext + 1'b1) : ref_ext;

   // one squarer shared by both sums
   assign mul_op  = (state_ff == ST_SQ_ERR) ? dabs_ff : rabs_ff;
   assign mul_out = mul_op * mul_op;

   // one saturating adder shared by both sums
   assign add_base = (state_ff == ST_SQ_REF) ? err_sum_ff : ref_sum_ff;
   assign add_out  = {1'b0, add_base} + {1'b0, prod_ff};
   assign add_sat  = add_out[SUM_W] ? '1 : add_out[SUM_W-1:0];

   assign ref_small = ref_sum_ff < REF_LIMIT;
   assign too_big   = ref_small && (err_sum_ff >= (ref_sum_ff << GUARD_SHIFT));

   always_comb begin
      state_in       = state_ff;
      dabs_in        = dabs_ff;
      rabs_in        = rabs_ff;
      last_in        = last_ff;
      prod_in        = prod_ff;
      err_sum_in     = err_sum_ff;
      ref_sum_in     = ref_sum_ff;
      clip_in        = clip_ff;
      ratio_in       = ratio_ff;
      zero_in        = zero_ff;
      sat_in         = sat_ff;
      rsp_valid_in   = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_ratio_in   = rsp_ratio_ff;
      rsp_zero_in    = rsp_zero_ff;
      rsp_sat_in     = rsp_sat_ff;
      unit_cmd       = '0;
      unit_cmd.dividend = err_sum_ff;
      unit_cmd.divisor  = ref_sum_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               dabs_in  = diff_mag[SAMPLE_BITS-1:0];
               rabs_in  = ref_mag[SAMPLE_BITS-1:0];
               last_in  = req_if.last_sample;
               state_in = ST_SQ_ERR;
            end
         end
         ST_SQ_ERR: begin
            prod_in  = SUM_W'(mul_out);
            state_in = ST_SQ_REF;
         end
         ST_SQ_REF: begin
            err_sum_in = add_sat;
            clip_in    = clip_ff | add_out[SUM_W];
            prod_in    = SUM_W'(mul_out);
            state_in   = ST_ADD_REF;
         end
         ST_ADD_REF: begin
            ref_sum_in = add_sat;
            clip_in    = clip_ff | add_out[SUM_W];
            state_in   = last_ff ? ST_CHECK : ST_IDLE;
         end
         ST_CHECK: begin
            zero_in  = (ref_sum_ff == '0);
            ratio_in = RATIO_MAX;
            if (ref_sum_ff == '0 || too_big) begin
               sat_in   = 1'b1;
               state_in = ST_OUT;
            end else begin
               sat_in         = clip_ff;
               unit_cmd.start = 1'b1;
               state_in       = ST_RUN;
            end
         end
         ST_RUN: begin
            if (unit_sts.done) begin
               ratio_in = unit_sts.root;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ratio_in = ratio_ff;
               rsp_zero_in  = zero_ff;
               rsp_sat_in   = sat_ff;
               err_sum_in   = '0;
               ref_sum_in   = '0;
               clip_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         err_sum_ff   <= '0;
         ref_sum_ff   <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         err_sum_ff   <= err_sum_in;
         ref_sum_ff   <= ref_sum_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dabs_ff      <= dabs_in;
      rabs_ff      <= rabs_in;
      last_ff      <= last_in;
      prod_ff      <= prod_in;
      ratio_ff     <= ratio_in;
      zero_ff      <= zero_in;
      sat_ff       <= sat_in;
      rsp_ratio_ff <= rsp_ratio_in;
      rsp_zero_ff  <= rsp_zero_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   nrmse_root_unit u_root (
      .clock (clock),
      .reset (reset),
      .cmd   (unit_cmd),
      .sts   (unit_sts)
   );

   assign req_if.ready          = (state_ff == ST_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.ratio_value    = rsp_ratio_ff;
   assign rsp_if.reference_zero = rsp_zero_ff;
   assign rsp_if.saturated      = rsp_sat_ff;

`ifndef SYNTHESIS
   a_zero_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.reference_zero |-> rsp_if.saturated
                                               && rsp_if.ratio_value == RATIO_MAX)
      else $error("zero reference without saturated result");

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      unit_sts.done |-> state_ff == ST_RUN)
      else $error("root unit finished outside run state");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && state_in == ST_IDLE |=> err_sum_ff == '0 && ref_sum_ff == '0
                                                    && !clip_ff && rsp_if.valid)
      else $error("sums not cleared after result transaction");
`endif

endmodule

// ----- rtl/core/nrmse_root_unit.sv -----
// nrmse_root_unit: restoring divide of dividend*2^48 by divisor, then integer square root
// one shared 65-bit subtractor serves both phases; depends on nrmse_pkg
`timescale 1ns / 1ps

module nrmse_root_unit (
   input  logic               clock,
   input  logic               reset,
   input  nrmse_pkg::cmd_type cmd,
   output nrmse_pkg::sts_type sts
);
   import nrmse_pkg::*;

   phase_type        phase_ff, phase_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [SUM_W-1:0] num_ff, num_in;
   logic [SUM_W-1:0] div_ff, div_in;

   logic [SUM_W:0]   op_a;
   logic [SUM_W:0]   op_b;
   logic [SUM_W:0]   diff;
   logic             take;
   logic [SUM_W-1:0] quo_next;

   // shared subtract and compare
   assign diff = op_a - op_b;
   assign take = !diff[SUM_W];

   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      num_in   = num_ff;
      div_in   = div_ff;
      op_a     = {1'b0, acc_ff};
      op_b     = {1'b0, quo_ff | num_ff};
      quo_next = {quo_ff[SUM_W-2:0], take};
      unique case (phase_ff)
         PH_IDLE: begin
            if (cmd.start) begin
               acc_in   = '0;
               quo_in   = '0;
               num_in   = cmd.dividend;
               div_in   = cmd.divisor;
               cnt_in   = CNT_W'(DIV_STEPS - 1);
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            // remainder with carry as top bit, next dividend bit shifted in
            op_a   = {acc_ff, num_ff[SUM_W-1]};
            op_b   = {1'b0, div_ff};
            acc_in = take ? diff[SUM_W-1:0] : op_a[SUM_W-1:0];
            num_in = {num_ff[SUM_W-2:0], 1'b0};
            quo_in = quo_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               acc_in   = quo_next;
               quo_in   = '0;
               num_in   = SQRT_BIT0;
               cnt_in   = CNT_W'(SQRT_STEPS - 1);
               phase_in = PH_SQRT;
            end
         end
         PH_SQRT: begin
            // res and bit never overlap, so or stands for add
            if (take) begin
               acc_in = diff[SUM_W-1:0];
               quo_in = (quo_ff >> 1) | num_ff;
            end else begin
               quo_in = quo_ff >> 1;
            end
            num_in = num_ff >> 2;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      num_ff <= num_in;
      div_ff <= div_in;
   end

   assign sts.done = done_ff;
   assign sts.root = quo_ff[RATIO_W-1:0];

endmodule

// ----- tb/sv/nrmse_norm_ratio_checker.sv -----
// nrmse_norm_ratio_checker: watches the sample and result channels, predicts each norm ratio
// depends on nrmse_pkg, nrmse_req_if and nrmse_rsp_if
`timescale 1ns / 1ps

module nrmse_norm_ratio_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   nrmse_req_if req_mon,
   nrmse_rsp_if rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   import nrmse_pkg::*;

   localparam int FRAC_SHIFT = 48;
   localparam int QUO_W      = SUM_W + FRAC_SHIFT;

   typedef struct {
      logic [RATIO_W-1:0] ratio_value;
      logic               reference_zero;
      logic               saturated;
   } ratio_result_type;

   ratio_result_type ratio_q[$];
   logic [SUM_W-1:0] err_sum  = '0;
   logic [SUM_W-1:0] ref_sum  = '0;
   logic             sum_clip = 1'b0;

   function automatic logic [SUM_W-1:0] square_of(input logic signed [SAMPLE_BITS:0] v);
      logic [SAMPLE_BITS:0] mag;
      mag = v[SAMPLE_BITS] ? -v : v;
      return SUM_W'(mag) * SUM_W'(mag);
   endfunction

   function automatic logic [RATIO_W-1:0] floor_root(input logic [SUM_W-1:0] x);
      logic [RATIO_W-1:0] root;
      logic [RATIO_W-1:0] trial;
      root = '0;
      for (int i = RATIO_W - 1; i >= 0; i--) begin
         trial = root | (RATIO_W'(1) << i);
         if (SUM_W'(trial) * SUM_W'(trial) <= x) root = trial;
      end
      return root;
   endfunction

   function automatic ratio_result_type norm_ratio(input logic [SUM_W-1:0] e,
                                                   input logic [SUM_W-1:0] r,
                                                   input logic             clipped);
      ratio_result_type res;
      logic [QUO_W-1:0] quo;
      res.ratio_value    = RATIO_MAX;
      res.reference_zero = 1'b0;
      res.saturated      = clipped;
      if (r == '0) begin
         res.reference_zero = 1'b1;
         res.saturated      = 1'b1;
      end else if (r < REF_LIMIT && e >= (r << GUARD_SHIFT)) begin
         res.saturated = 1'b1;
      end else begin
         quo = {e, {FRAC_SHIFT{1'b0}}} / QUO_W'(r);
         res.ratio_value = floor_root(quo[SUM_W-1:0]);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      logic signed [SAMPLE_BITS:0] p_ext;
      logic signed [SAMPLE_BITS:0] r_ext;
      logic [SUM_W:0]              err_next;
      logic [SUM_W:0]              ref_next;
      ratio_result_type            want;
      if (reset) begin
         ratio_q.delete();
         err_sum       = '0;
         ref_sum       = '0;
         sum_clip      = 1'b0;
         fail_count    = 0;
         pending_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            p_ext    = {req_mon.predicted[SAMPLE_BITS-1], req_mon.predicted};
            r_ext    = {req_mon.reference[SAMPLE_BITS-1], req_mon.reference};
            err_next = {1'b0, err_sum} + square_of(p_ext - r_ext);
            ref_next = {1'b0, ref_sum} + square_of(r_ext);
            err_sum  = err_next[SUM_W] ? '1 : err_next[SUM_W-1:0];
            ref_sum  = ref_next[SUM_W] ? '1 : ref_next[SUM_W-1:0];
            sum_clip = sum_clip | err_next[SUM_W] | ref_next[SUM_W];
            if (req_mon.last_sample) begin
               ratio_q.push_back(norm_ratio(err_sum, ref_sum, sum_clip));
               err_sum  = '0;
               ref_sum  = '0;
               sum_clip = 1'b0;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (ratio_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result transaction with no set pending: ratio %h zero %b sat %b",
                           $realtime, rsp_mon.ratio_value, rsp_mon.reference_zero,
                           rsp_mon.saturated);
               fail_count++;
            end else begin
               want = ratio_q.pop_front();
               if (rsp_mon.ratio_value !== want.ratio_value ||
                   rsp_mon.reference_zero !== want.reference_zero ||
                   rsp_mon.saturated !== want.saturated) begin
                  if (fail_count < 10)
                     $display(
                        "%0t: ratio mismatch: expected %h zero %b sat %b, got %h zero %b sat %b",
                        $realtime, want.ratio_value, want.reference_zero, want.saturated,
                        rsp_mon.ratio_value, rsp_mon.reference_zero, rsp_mon.saturated);
                  fail_count++;
               end
            end
         end
         pending_count = ratio_q.size();
      end
   end

endmodule

// ----- tb/sv/tb_nrmse_norm_ratio_top.sv -----
// tb_nrmse_norm_ratio_top: sample pair stimulus for nrmse_norm_ratio_top and the final verdict
// depends on nrmse_pkg, nrmse_req_if, nrmse_rsp_if, the block and nrmse_norm_ratio_checker
`timescale 1ns / 1ps

module tb_nrmse_norm_ratio_top;

   localparam int SAMPLE_BITS  = 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 400;
   localparam int PHASE_ITEMS  = 300;

   typedef enum int {
      SET_RANDOM,
      SET_CLOSE,
      SET_TINY_REF,
      SET_ZERO_REF,
      SET_EXACT,
      SET_CORNER
   } set_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   idle_pct    = 0;
   int   stall_pct   = 0;
   int   items_sent  = 0;
   int   cycle_count = 0;
   int   fail_count;
   int   pending_count;

   nrmse_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   nrmse_rsp_if rsp_ch ();

   nrmse_norm_ratio_top #(.SAMPLE_BITS(SAMPLE_BITS)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   nrmse_norm_ratio_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL nrmse_norm_ratio_top");
         $finish;
      end
   end

   task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] p,
                            input logic signed [SAMPLE_BITS-1:0] r, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.predicted   <= p;
      req_ch.reference   <= r;
      req_ch.last_sample <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // hold off the sender until every pending ratio has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] corner_sample();
      case ($urandom_range(4))
         0:       return 16'sh8000;
         1:       return -16'sd1;
         2:       return 16'sd0;
         3:       return 16'sd1;
         default: return 16'sh7FFF;
      endcase
   endfunction

   task automatic send_random_set();
      set_kind_type                  kind;
      int                            len;
      int                            pick;
      logic signed [SAMPLE_BITS-1:0] p;
      logic signed [SAMPLE_BITS-1:0] r;
      pick = $urandom_range(9);
      case (pick)
         0, 1, 2, 3: kind = SET_RANDOM;
         4, 5:       kind = SET_CLOSE;
         6:          kind = SET_TINY_REF;
         7:          kind = SET_ZERO_REF;
         8:          kind = SET_EXACT;
         default:    kind = SET_CORNER;
      endcase
      len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
         p = SAMPLE_BITS'($urandom);
         r = SAMPLE_BITS'($urandom);
         case (kind)
            SET_CLOSE:    p = r + SAMPLE_BITS'($urandom_range(511)) - 16'sd256;
            SET_TINY_REF: r = SAMPLE_BITS'($urandom_range(8)) - 16'sd4;
            SET_ZERO_REF: begin
               r = '0;
               if ($urandom_range(1) == 0) p = '0;
            end
            SET_EXACT:    p = r;
            SET_CORNER: begin
               p = corner_sample();
               r = corner_sample();
            end
            default: ;
         endcase
         send_pair(p, r, k == len - 1);
      end
   endtask

   task automatic run_phase(input int idle, input int stall);
      int start;
      idle_pct  = idle;
      stall_pct = stall;
      start     = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_random_set();
      wait_drained();
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.predicted   = '0;
      req_ch.reference   = '0;
      req_ch.last_sample = 1'b0;
      rsp_ch.ready       = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // full scale error, both signs
      send_pair(16'sh7FFF, 16'sh8000, 1'b1);
      send_pair(16'sh8000, 16'sh7FFF, 1'b1);
      // zero reference, with and without error
      send_pair(16'sd0, 16'sd0, 1'b1);
      send_pair(16'sd100, 16'sd0, 1'b1);
      // zero error and unit ratio
      send_pair(16'sd5, 16'sd5, 1'b1);
      send_pair(16'sd0, 16'sd1234, 1'b1);
      // ratio just below, just at and above 256
      send_pair(16'sd256, 16'sd1, 1'b1);
      send_pair(16'sd257, 16'sd1, 1'b1);
      send_pair(16'sh8000, 16'sd1, 1'b1);
      // multi pair sets, then two single pair sets
      send_pair(16'sd1000, 16'sd900, 1'b0);
      send_pair(-16'sd500, -16'sd400, 1'b0);
      send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
      send_pair(16'sd0, 16'sh8000, 1'b1);
      send_pair(16'sd7, 16'sd0, 1'b0);
      send_pair(16'sd0, 16'sd0, 1'b0);
      send_pair(16'sd3, 16'sd2, 1'b1);
      send_pair(16'sh8000, 16'sh8000, 1'b1);
      send_pair(16'sd0, -16'sd1, 1'b1);
      wait_drained();

      run_phase(0, 0);
      run_phase(66, 0);
      run_phase(0, 66);
      run_phase(12, 12);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS nrmse_norm_ratio_top");
      else
         $display("FAIL nrmse_norm_ratio_top");
      $finish;
   end

endmodule
